### hw/rtl/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

    localparam int unsigned HEAP_BYTES_DEF = 65536;
    localparam int unsigned HDR_BYTES      = 8;
    localparam int unsigned SPLIT_MIN      = 16;
    localparam int unsigned MAX_REQ        = 65536;

    localparam int REQ_W  = 17;
    localparam int BLK_W  = 14;
    localparam int ADDR_W = 32;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OOM       = 2'd1,
        ST_NULL_FREE = 2'd2,
        ST_BAD_FREE  = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [REQ_W-1:0]  req_bytes;
        logic [ADDR_W-1:0] free_addr;
    } ffha_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] alloc_addr;
        status_t           status;
        logic [REQ_W-1:0]  used_bytes;
        logic [BLK_W-1:0]  used_blocks;
    } ffha_rsp_t;

endpackage

### hw/rtl/ffha_hdr_mem.sv
// Header memory: one size/free word per 4-byte slot, registered read port.
module ffha_hdr_mem #(
    parameter int unsigned HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF,
    localparam int OW      = $clog2(HEAP_BYTES),
    localparam int SLOT_AW = $clog2(HEAP_BYTES / 4)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               rd_en,
    input  logic [SLOT_AW-1:0] rd_addr,
    output logic [OW-1:0]      rd_size,
    output logic               rd_free,
    input  logic               wr_en,
    input  logic [SLOT_AW-1:0] wr_addr,
    input  logic [OW-1:0]      wr_size,
    input  logic               wr_free
);
    import ffha_pkg::*;

    localparam int unsigned DEPTH = HEAP_BYTES / 4;
    localparam logic [OW-1:0] INIT_SIZE = OW'(HEAP_BYTES - 2 * HDR_BYTES);

    logic [OW:0] hdr_mem [DEPTH];
    logic [OW:0] rd_word_reg;
    logic        fresh_reg;     // slot 0 still holds its reset header
    logic        rd_fresh_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hdr_mem[wr_addr] <= {wr_free, wr_size};
        end
        if (rd_en) begin
            rd_word_reg <= hdr_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fresh_reg    <= 1'b1;
            rd_fresh_reg <= 1'b0;
        end else begin
            if (wr_en && (wr_addr == '0)) begin
                fresh_reg <= 1'b0;
            end
            if (rd_en) begin
                rd_fresh_reg <= fresh_reg && (rd_addr == '0);
            end
        end
    end

    assign rd_size = rd_fresh_reg ? INIT_SIZE : rd_word_reg[OW-1:0];
    assign rd_free = rd_fresh_reg ? 1'b1 : rd_word_reg[OW];

endmodule

### hw/rtl/ffha_ctrl.sv
// Request sequencer: chain walks, split, mark, coalescing pass and usage counters.
module ffha_ctrl #(
    parameter int unsigned HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF,
    localparam int OW      = $clog2(HEAP_BYTES),
    localparam int SLOT_AW = $clog2(HEAP_BYTES / 4)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [31:0]         heap_base,
    input  logic                req_valid,
    output logic                req_ready,
    input  ffha_pkg::ffha_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ffha_pkg::ffha_rsp_t rsp,
    output logic                mem_rd_en,
    output logic [SLOT_AW-1:0]  mem_rd_addr,
    input  logic [OW-1:0]       mem_rd_size,
    input  logic                mem_rd_free,
    output logic                mem_wr_en,
    output logic [SLOT_AW-1:0]  mem_wr_addr,
    output logic [OW-1:0]       mem_wr_size,
    output logic                mem_wr_free
);
    import ffha_pkg::*;

    localparam int CW = ((OW > REQ_W) ? OW : REQ_W) + 2;
    localparam logic [CW-1:0]    SENT_W  = CW'(HEAP_BYTES - HDR_BYTES);
    localparam logic [CW-1:0]    HDR_W   = CW'(HDR_BYTES);
    localparam logic [CW-1:0]    SPLIT_W = CW'(HDR_BYTES + SPLIT_MIN);
    localparam logic [31:0]      SENT_32 = 32'(HEAP_BYTES - HDR_BYTES);
    localparam logic [31:0]      HDR_32  = 32'(HDR_BYTES);
    localparam logic [REQ_W-1:0] MAX_RQ  = REQ_W'(MAX_REQ);

    typedef enum logic [2:0] {
        S_IDLE,
        S_A_WALK,
        S_A_SPLIT,
        S_F_WALK,
        S_M_START,
        S_M_CUR,
        S_M_NXT,
        S_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic [OW-1:0]     off_reg, off_next;        // offset whose header is on the read port
    logic [REQ_W-1:0]  need_reg, need_next;
    logic [OW-1:0]     target_reg, target_next;
    logic [OW-1:0]     cur_reg, cur_next;        // left block of the coalescing pass
    logic [OW-1:0]     cur_size_reg, cur_size_next;
    logic              cur_free_reg, cur_free_next;
    logic [OW-1:0]     split_off_reg, split_off_next;
    logic [OW-1:0]     split_size_reg, split_size_next;
    logic [31:0]       addr_reg, addr_next;
    status_t           status_reg, status_next;
    logic [REQ_W-1:0]  bytes_reg, bytes_next;
    logic [BLK_W-1:0]  blocks_reg, blocks_next;

    logic [CW-1:0]     walk_nxt;
    logic [CW-1:0]     merge_size;
    logic [CW-1:0]     rem_size;
    logic [CW-1:0]     split_off;
    logic              fits;
    logic              do_split;
    logic [REQ_W-1:0]  req_nz;
    logic [REQ_W-1:0]  need_rnd;
    logic [31:0]       target32;

    assign walk_nxt   = CW'(off_reg) + HDR_W + CW'(mem_rd_size);
    assign merge_size = CW'(cur_size_reg) + HDR_W + CW'(mem_rd_size);
    assign rem_size   = CW'(mem_rd_size) - CW'(need_reg) - HDR_W;
    assign split_off  = CW'(off_reg) + HDR_W + CW'(need_reg);
    assign fits       = mem_rd_free && (CW'(mem_rd_size) >= CW'(need_reg));
    assign do_split   = CW'(mem_rd_size) >= (CW'(need_reg) + SPLIT_W);
    assign req_nz     = (req.req_bytes == '0) ? REQ_W'(1) : req.req_bytes;
    assign need_rnd   = (req_nz + REQ_W'(3)) & ~REQ_W'(3);
    assign target32   = req.free_addr - heap_base - HDR_32;

    always_comb begin
        state_next      = state_reg;
        off_next        = off_reg;
        need_next       = need_reg;
        target_next     = target_reg;
        cur_next        = cur_reg;
        cur_size_next   = cur_size_reg;
        cur_free_next   = cur_free_reg;
        split_off_next  = split_off_reg;
        split_size_next = split_size_reg;
        addr_next       = addr_reg;
        status_next     = status_reg;
        bytes_next      = bytes_reg;
        blocks_next     = blocks_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = '0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = off_reg[SLOT_AW+1:2];
        mem_wr_size     = mem_rd_size;
        mem_wr_free     = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    addr_next = '0;
                    off_next  = '0;
                    if (req.cmd == CMD_ALLOC) begin
                        if (req.req_bytes > MAX_RQ) begin
                            status_next = ST_OOM;
                            state_next  = S_RESP;
                        end else begin
                            need_next  = need_rnd;
                            mem_rd_en  = 1'b1;
                            state_next = S_A_WALK;
                        end
                    end else begin
                        if (req.free_addr == '0) begin
                            status_next = ST_NULL_FREE;
                            state_next  = S_RESP;
                        end else if (target32 >= SENT_32) begin
                            status_next = ST_BAD_FREE;
                            state_next  = S_RESP;
                        end else begin
                            target_next = OW'(target32);
                            mem_rd_en   = 1'b1;
                            state_next  = S_F_WALK;
                        end
                    end
                end
            end

            S_A_WALK: begin
                if (fits) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_free = 1'b0;
                    blocks_next = blocks_reg + BLK_W'(1);
                    addr_next   = heap_base + 32'(off_reg) + HDR_32;
                    status_next = ST_OK;
                    if (do_split) begin
                        mem_wr_size     = OW'(need_reg);
                        bytes_next      = bytes_reg + need_reg;
                        split_off_next  = OW'(split_off);
                        split_size_next = OW'(rem_size);
                        state_next      = S_A_SPLIT;
                    end else begin
                        mem_wr_size = mem_rd_size;
                        bytes_next  = bytes_reg + REQ_W'(mem_rd_size);
                        state_next  = S_RESP;
                    end
                end else if (walk_nxt >= SENT_W) begin
                    addr_next   = '0;
                    status_next = ST_OOM;
                    state_next  = S_RESP;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = walk_nxt[SLOT_AW+1:2];
                    off_next    = OW'(walk_nxt);
                end
            end

            S_A_SPLIT: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = split_off_reg[SLOT_AW+1:2];
                mem_wr_size = split_size_reg;
                mem_wr_free = 1'b1;
                state_next  = S_RESP;
            end

            S_F_WALK: begin
                if (off_reg == target_reg) begin
                    if (!mem_rd_free) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_size = mem_rd_size;
                        mem_wr_free = 1'b1;
                        bytes_next  = bytes_reg - REQ_W'(mem_rd_size);
                        blocks_next = blocks_reg - BLK_W'(1);
                        status_next = ST_OK;
                        state_next  = S_M_START;
                    end else begin
                        status_next = ST_BAD_FREE;
                        state_next  = S_RESP;
                    end
                end else if ((walk_nxt >= SENT_W) || (walk_nxt > CW'(target_reg))) begin
                    status_next = ST_BAD_FREE;
                    state_next  = S_RESP;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = walk_nxt[SLOT_AW+1:2];
                    off_next    = OW'(walk_nxt);
                end
            end

            // Read of slot 0 is issued in the cycle after the mark write, so it never meets it.
            S_M_START: begin
                mem_rd_en  = 1'b1;
                off_next   = '0;
                state_next = S_M_CUR;
            end

            S_M_CUR: begin
                cur_next      = off_reg;
                cur_size_next = mem_rd_size;
                cur_free_next = mem_rd_free;
                if (walk_nxt >= SENT_W) begin
                    state_next = S_RESP;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = walk_nxt[SLOT_AW+1:2];
                    off_next    = OW'(walk_nxt);
                    state_next  = S_M_NXT;
                end
            end

            // Header on the read port follows cur; the block after it is
            // off + 8 + size in both cases (merged size ends at the same place).
            S_M_NXT: begin
                if (cur_free_reg && mem_rd_free) begin
                    mem_wr_en     = 1'b1;
                    mem_wr_addr   = cur_reg[SLOT_AW+1:2];
                    mem_wr_size   = OW'(merge_size);
                    mem_wr_free   = 1'b1;
                    cur_size_next = OW'(merge_size);
                end else begin
                    cur_next      = off_reg;
                    cur_size_next = mem_rd_size;
                    cur_free_next = mem_rd_free;
                end
                if (walk_nxt >= SENT_W) begin
                    state_next = S_RESP;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = walk_nxt[SLOT_AW+1:2];
                    off_next    = OW'(walk_nxt);
                end
            end

            S_RESP: begin
                if (rsp_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            bytes_reg  <= '0;
            blocks_reg <= '0;
        end else begin
            state_reg      <= state_next;
            off_reg        <= off_next;
            need_reg       <= need_next;
            target_reg     <= target_next;
            cur_reg        <= cur_next;
            cur_size_reg   <= cur_size_next;
            cur_free_reg   <= cur_free_next;
            split_off_reg  <= split_off_next;
            split_size_reg <= split_size_next;
            addr_reg       <= addr_next;
            status_reg     <= status_next;
            bytes_reg      <= bytes_next;
            blocks_reg     <= blocks_next;
        end
    end

    assign req_ready       = (state_reg == S_IDLE);
    assign rsp_valid       = (state_reg == S_RESP);
    assign rsp.alloc_addr  = addr_reg;
    assign rsp.status      = status_reg;
    assign rsp.used_bytes  = bytes_reg;
    assign rsp.used_blocks = blocks_reg;

endmodule

### hw/rtl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: config register, result register, checks.
//
// First-fit heap metadata manager. One request enters on s_ (valid/ready, payload
// s_req: cmd, req_bytes, free_addr) and gives exactly one result on m_ (valid/ready,
// payload m_rsp: alloc_addr, status, used_bytes, used_blocks).
// heap_base is written over cfg_valid/cfg_ready/cfg_data, always ready; write it only
// while no request is in flight.
// Timing: the sequencer walks the block chain in header memory, one header per cycle
// off the single read port of the header RAM.
//   alloc: walks the chain to the first free block that fits; a split adds the remainder write.
//   free:  walks the chain up to the block, marks it free, and then
//          runs the coalescing pass over all blocks of the chain. A null or bad free
//          ends after the blocks walked so far, with no walk when rejected up front.
// One request at a time; the next is taken once the result is loaded into the
// output register, so a stalled receiver holds one finished result while the
// next request is already being worked.
// Reset: slot 0 reads as one free block covering the heap (tracked by a flag, no
// clearing pass); counters go to zero, heap_base to 0.
module first_fit_heap_allocator #(
    parameter int unsigned HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ffha_pkg::ffha_req_t s_req,
    output logic                m_valid,
    input  logic                m_ready,
    output ffha_pkg::ffha_rsp_t m_rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data
);
    import ffha_pkg::*;

    localparam int OW      = $clog2(HEAP_BYTES);
    localparam int SLOT_AW = $clog2(HEAP_BYTES / 4);

    logic [31:0]        heap_base_reg;
    logic               m_valid_reg;
    ffha_rsp_t          m_rsp_reg;

    logic               ctrl_rsp_valid;
    logic               ctrl_rsp_ready;
    ffha_rsp_t          ctrl_rsp;

    logic               mem_rd_en;
    logic [SLOT_AW-1:0] mem_rd_addr;
    logic [OW-1:0]      mem_rd_size;
    logic               mem_rd_free;
    logic               mem_wr_en;
    logic [SLOT_AW-1:0] mem_wr_addr;
    logic [OW-1:0]      mem_wr_size;
    logic               mem_wr_free;

    // config: single register, never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            heap_base_reg <= cfg_data;
        end
    end

    ffha_ctrl #(
        .HEAP_BYTES(HEAP_BYTES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .heap_base   (heap_base_reg),
        .req_valid   (s_valid),
        .req_ready   (s_ready),
        .req         (s_req),
        .rsp_valid   (ctrl_rsp_valid),
        .rsp_ready   (ctrl_rsp_ready),
        .rsp         (ctrl_rsp),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_size (mem_rd_size),
        .mem_rd_free (mem_rd_free),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_size (mem_wr_size),
        .mem_wr_free (mem_wr_free)
    );

    ffha_hdr_mem #(
        .HEAP_BYTES(HEAP_BYTES)
    ) u_hdr_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_size (mem_rd_size),
        .rd_free (mem_rd_free),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_size (mem_wr_size),
        .wr_free (mem_wr_free)
    );

    // result register: loads when empty or being drained this cycle
    assign ctrl_rsp_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl_rsp_valid && ctrl_rsp_ready) begin
            m_valid_reg <= 1'b1;
            m_rsp_reg   <= ctrl_rsp;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    // one request in the sequencer at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while sequencer busy");

    // a granted address only comes with a successful status
    a_addr_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_rsp.alloc_addr != '0)) |-> (m_rsp.status == ST_OK))
        else $error("nonzero address on a failed or free result");

    // a finished result waits in the sequencer while the output register is full
    a_rsp_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_rsp_valid && !ctrl_rsp_ready) |=> ctrl_rsp_valid)
        else $error("result dropped while output register full");

endmodule
